// File: src/vcs_pkg.sv
// Shared constants and helpers for the cloth step engine.
`default_nettype none
package vcs_pkg;
   localparam int MaxPoints = 1024;
   localparam int MaxLinks  = 4096;
   localparam int FracBits  = 16;
   localparam int MaxPasses = 64;

   typedef enum logic [1:0] {
      ACT_LOAD_POINT = 2'd0,
      ACT_LOAD_LINK  = 2'd1,
      ACT_STEP       = 2'd2,
      ACT_READ_POINT = 2'd3
   } action_type;

   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_POINT = 2'd2;

   localparam logic [2:0] REG_GRAV_X = 3'd0;
   localparam logic [2:0] REG_GRAV_Y = 3'd1;
   localparam logic [2:0] REG_GRAV_Z = 3'd2;
   localparam logic [2:0] REG_REST   = 3'd3;
   localparam logic [2:0] REG_PASSES = 3'd4;
   localparam logic [2:0] REG_POINTS = 3'd5;
   localparam logic [2:0] REG_LINKS  = 3'd6;

   // Clamp a 66-bit signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      if (v < -66'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction
endpackage
`default_nettype wire

// File: src/vcs_divsqrt.sv
// Shared iterative unit: radix-2 integer square root and unsigned divide.
`default_nettype none
module vcs_divsqrt (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic         is_sqrt,
   input  wire logic [95:0]  num,
   input  wire logic [63:0]  den,
   output logic              done,
   output logic [95:0]       quo
);
   logic [95:0] rem_ff, rem_in, q_ff, q_in, n_ff, n_in;
   logic [63:0] d_ff, d_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, sq_ff, sq_in, done_ff, done_in;
   logic [97:0] trial;
   logic [97:0] rsh;

   always_comb begin
      rem_in = rem_ff; q_in = q_ff; n_in = n_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; sq_in = sq_ff; done_in = 1'b0;
      rsh = '0; trial = '0;
      if (start) begin
         rem_in = '0; q_in = '0; n_in = num; d_in = den; sq_in = is_sqrt;
         busy_in = 1'b1; cnt_in = is_sqrt ? 7'd32 : 7'd96;
      end else if (busy_ff) begin
         // advance one digit
         if (sq_ff) begin
            rsh = {rem_ff[95:0], n_ff[63:62]};
            trial = {32'd0, q_ff[63:0], 2'b01};
            n_in = {n_ff[95:0] << 2};
         end else begin
            rsh = {1'b0, rem_ff, n_ff[95]};
            trial = {34'd0, d_ff};
            n_in = {n_ff[94:0], 1'b0};
         end
         if (rsh >= trial) begin
            rem_in = 96'(rsh - trial);
            q_in = {q_ff[94:0], 1'b1};
         end else begin
            rem_in = rsh[95:0];
            q_in = {q_ff[94:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; q_ff <= q_in; n_ff <= n_in; d_ff <= d_in; sq_ff <= sq_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;
endmodule
`default_nettype wire

// File: src/verlet_cloth_step.sv
// Top level of the cloth step engine: stores, sequencer and handshakes.
//
// Cloth step engine with position Verlet integration and distance links. A step
// visits every point, then for each pass and each active link performs memory
// access, a square root and three divides in the shared divide/square root unit,
// which sets the step time. One transaction is in flight at a time; req_stall is
// high while it runs or its response waits.
// Stores are undefined until written and need no clearing pass.
`default_nettype none
module verlet_cloth_step #(
   parameter int MAX_POINTS = vcs_pkg::MaxPoints,
   parameter int MAX_LINKS  = vcs_pkg::MaxLinks,
   parameter int FRAC_BITS  = vcs_pkg::FracBits,
   parameter int MAX_PASSES = vcs_pkg::MaxPasses
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_action,
   input  wire logic [11:0]        req_index,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_pos_z,
   input  wire logic               req_flag,
   input  wire logic [9:0]         req_end_a,
   input  wire logic [9:0]         req_end_b,
   input  wire logic signed [31:0] req_wind_x,
   input  wire logic signed [31:0] req_wind_y,
   input  wire logic signed [31:0] req_wind_z,
   input  wire logic [16:0]        req_time_step,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_kind,
   output logic signed [31:0]      rsp_out_x,
   output logic signed [31:0]      rsp_out_y,
   output logic signed [31:0]      rsp_out_z,
   output logic                    rsp_out_pinned,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_data
);
   localparam int PW = $clog2(MAX_POINTS);
   localparam int LW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
   localparam int PCW = $clog2(MAX_POINTS + 1);
   localparam int LCW = $clog2(MAX_LINKS + 1);
   localparam int MinLen = ((1 << FRAC_BITS) + 9999) / 10000;

   typedef enum logic [4:0] {
      S_IDLE, S_RD_PT, S_RESP, S_STEP_ACC, S_STEP_MUL, S_PT_RD, S_PT_WAIT, S_PT_WR,
      S_LK_RD, S_LK_WAIT, S_LK_PRD, S_LK_PWAIT, S_LK_AXIS, S_LK_SQ, S_LK_SUM,
      S_LK_SQRT, S_LK_DIV, S_LK_WA, S_LK_WB, S_LK_NEXT
   } state_type;

   // Stores
   logic signed [31:0] cx_mem [MAX_POINTS];
   logic signed [31:0] cy_mem [MAX_POINTS];
   logic signed [31:0] cz_mem [MAX_POINTS];
   logic signed [31:0] px_mem [MAX_POINTS];
   logic signed [31:0] py_mem [MAX_POINTS];
   logic signed [31:0] pz_mem [MAX_POINTS];
   logic               pin_mem [MAX_POINTS];
   logic [20:0]        link_mem [MAX_LINKS];

   // Configuration
   logic signed [31:0] grav_ff [3];
   logic [30:0] rest_ff;
   logic [6:0]  passes_ff;
   logic [10:0] npts_ff;
   logic [12:0] nlinks_ff;

   state_type state_ff;
   logic [1:0]  act_ff;
   logic [11:0] idx_ff;
   logic signed [31:0] pos_ff [3];
   logic        flag_ff;
   logic [9:0]  ea_ff, eb_ff;
   logic signed [31:0] wind_ff [3];
   logic [16:0] dt_ff;
   logic [33:0] dt2_ff;
   logic signed [31:0] acc_ff [3];
   logic signed [65:0] term_ff [3];
   logic [1:0]  ax_ff;
   logic [PCW-1:0] pi_ff;
   logic [LCW-1:0] li_ff;
   logic [8:0]  pass_ff;
   logic        rsp_valid_ff;
   logic [1:0]  kind_ff;
   logic signed [31:0] ox_ff, oy_ff, oz_ff;
   logic        opin_ff;
   // memory read data
   logic signed [31:0] rc_ff [3];
   logic signed [31:0] rp_ff [3];
   logic        rpin_ff;
   logic [20:0] rlink_ff;
   // link working state
   logic [PW-1:0] la_ff, lb_ff;
   logic        pa_ff, pb_ff;
   logic signed [31:0] ca_ff [3];
   logic signed [31:0] cb_ff [3];
   logic signed [31:0] axis_ff [3];
   logic [63:0] sq_ff [3];
   logic signed [33:0] delta_ff;
   logic signed [33:0] sq_delta;
   logic signed [33:0] corr_ff [3];
   logic        dstart_ff, dsq_ff;
   logic [95:0] dnum_ff;
   logic [63:0] dden_ff;
   logic        dneg_ff;
   logic        ddone;
   logic [95:0] dquo;
   logic [PW-1:0] rd_addr;
   logic        rd_en;
   logic        req_acc, np_over, nl_over, pass_over;
   logic [PCW-1:0] np_eff;
   logic [LCW-1:0] nl_eff;
   logic [8:0]  npass_eff;

   vcs_divsqrt u_unit (
      .clock(clock), .reset(reset), .start(dstart_ff), .is_sqrt(dsq_ff),
      .num(dnum_ff), .den(dden_ff), .done(ddone), .quo(dquo)
   );

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !req_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = kind_ff;
   assign rsp_out_x = ox_ff;
   assign rsp_out_y = oy_ff;
   assign rsp_out_z = oz_ff;
   assign rsp_out_pinned = opin_ff;

   // Signed distance to the rest length from the fresh square root
   assign sq_delta = $signed(34'(rest_ff)) - $signed(34'(dquo[31:0]));

   // Clamp counts to the store sizes
   assign np_over = 32'(npts_ff) > 32'(MAX_POINTS);
   assign nl_over = 32'(nlinks_ff) > 32'(MAX_LINKS);
   assign pass_over = 32'(passes_ff) > 32'(MAX_PASSES);
   assign np_eff = np_over ? PCW'(MAX_POINTS) : PCW'(npts_ff);
   assign nl_eff = nl_over ? LCW'(MAX_LINKS) : LCW'(nlinks_ff);
   assign npass_eff = pass_over ? 9'(MAX_PASSES) : 9'(passes_ff);

   // Point read address
   always_comb begin
      rd_addr = PW'(pi_ff);
      rd_en = 1'b0;
      unique case (state_ff)
         S_RD_PT: begin rd_addr = idx_ff[PW-1:0]; rd_en = 1'b1; end
         S_PT_RD: begin rd_addr = PW'(pi_ff); rd_en = 1'b1; end
         S_LK_PRD: begin rd_addr = la_ff; rd_en = 1'b1; end
         S_LK_PWAIT: begin rd_addr = lb_ff; rd_en = 1'b1; end
         default: ;
      endcase
   end

   // Point store read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rc_ff[0] <= cx_mem[rd_addr]; rc_ff[1] <= cy_mem[rd_addr];
         rc_ff[2] <= cz_mem[rd_addr];
         rp_ff[0] <= px_mem[rd_addr]; rp_ff[1] <= py_mem[rd_addr];
         rp_ff[2] <= pz_mem[rd_addr];
         rpin_ff <= pin_mem[rd_addr];
      end
      if (state_ff == S_LK_RD) rlink_ff <= link_mem[LW'(li_ff)];
   end

   // Point and link store write port
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_acc && req_action == vcs_pkg::ACT_LOAD_POINT
          && 32'(req_index) < 32'(MAX_POINTS)) begin
         cx_mem[req_index[PW-1:0]] <= req_pos_x; px_mem[req_index[PW-1:0]] <= req_pos_x;
         cy_mem[req_index[PW-1:0]] <= req_pos_y; py_mem[req_index[PW-1:0]] <= req_pos_y;
         cz_mem[req_index[PW-1:0]] <= req_pos_z; pz_mem[req_index[PW-1:0]] <= req_pos_z;
         pin_mem[req_index[PW-1:0]] <= req_flag;
      end else if (state_ff == S_PT_WR && !rpin_ff) begin
         cx_mem[PW'(pi_ff)] <= vcs_pkg::sat32(66'(rc_ff[0]) + 66'(rc_ff[0]) - 66'(rp_ff[0])
                                              + term_ff[0]);
         cy_mem[PW'(pi_ff)] <= vcs_pkg::sat32(66'(rc_ff[1]) + 66'(rc_ff[1]) - 66'(rp_ff[1])
                                              + term_ff[1]);
         cz_mem[PW'(pi_ff)] <= vcs_pkg::sat32(66'(rc_ff[2]) + 66'(rc_ff[2]) - 66'(rp_ff[2])
                                              + term_ff[2]);
         px_mem[PW'(pi_ff)] <= rc_ff[0]; py_mem[PW'(pi_ff)] <= rc_ff[1];
         pz_mem[PW'(pi_ff)] <= rc_ff[2];
      end else if (state_ff == S_LK_WA && !pa_ff) begin
         cx_mem[la_ff] <= vcs_pkg::sat32(66'(ca_ff[0]) + 66'(corr_ff[0]));
         cy_mem[la_ff] <= vcs_pkg::sat32(66'(ca_ff[1]) + 66'(corr_ff[1]));
         cz_mem[la_ff] <= vcs_pkg::sat32(66'(ca_ff[2]) + 66'(corr_ff[2]));
      end else if (state_ff == S_LK_WB && !pb_ff) begin
         cx_mem[lb_ff] <= vcs_pkg::sat32(66'(cb_ff[0]) - 66'(corr_ff[0]));
         cy_mem[lb_ff] <= vcs_pkg::sat32(66'(cb_ff[1]) - 66'(corr_ff[1]));
         cz_mem[lb_ff] <= vcs_pkg::sat32(66'(cb_ff[2]) - 66'(corr_ff[2]));
      end
      if (state_ff == S_IDLE && req_acc && req_action == vcs_pkg::ACT_LOAD_LINK
          && 32'(req_index) < 32'(MAX_LINKS))
         link_mem[LW'(req_index)] <= {req_flag, req_end_a, req_end_b};
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         dstart_ff <= 1'b0;
         grav_ff[0] <= '0; grav_ff[1] <= -32'sd642253; grav_ff[2] <= '0;
         rest_ff <= 31'd65536; passes_ff <= 7'd8; npts_ff <= '0; nlinks_ff <= '0;
      end else begin
         dstart_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               vcs_pkg::REG_GRAV_X: grav_ff[0] <= csr_data;
               vcs_pkg::REG_GRAV_Y: grav_ff[1] <= csr_data;
               vcs_pkg::REG_GRAV_Z: grav_ff[2] <= csr_data;
               vcs_pkg::REG_REST:   rest_ff <= csr_data[30:0];
               vcs_pkg::REG_PASSES: passes_ff <= csr_data[6:0];
               vcs_pkg::REG_POINTS: npts_ff <= csr_data[10:0];
               vcs_pkg::REG_LINKS:  nlinks_ff <= csr_data[12:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  act_ff <= req_action; idx_ff <= req_index;
                  wind_ff[0] <= req_wind_x; wind_ff[1] <= req_wind_y;
                  wind_ff[2] <= req_wind_z; dt_ff <= req_time_step;
                  kind_ff <= vcs_pkg::KIND_ACK;
                  ox_ff <= '0; oy_ff <= '0; oz_ff <= '0; opin_ff <= 1'b0;
                  unique case (req_action)
                     vcs_pkg::ACT_LOAD_POINT, vcs_pkg::ACT_LOAD_LINK: begin
                        rsp_valid_ff <= 1'b1; state_ff <= S_RESP;
                     end
                     vcs_pkg::ACT_STEP: state_ff <= S_STEP_ACC;
                     default: begin
                        kind_ff <= vcs_pkg::KIND_POINT;
                        if (32'(req_index) < 32'(MAX_POINTS)) state_ff <= S_RD_PT;
                        else begin rsp_valid_ff <= 1'b1; state_ff <= S_RESP; end
                     end
                  endcase
               end
            end
            S_RD_PT: state_ff <= S_PT_WAIT;
            S_RESP: begin
               if (!rsp_stall) begin rsp_valid_ff <= 1'b0; state_ff <= S_IDLE; end
            end
            S_STEP_ACC: begin
               // acceleration and dt squared
               for (int k = 0; k < 3; k++)
                  acc_ff[k] <= vcs_pkg::sat32(66'(grav_ff[k]) + 66'(wind_ff[k]));
               dt2_ff <= 34'((35'(dt_ff) * 35'(dt_ff)) >> FRAC_BITS);
               ax_ff <= 2'd0;
               state_ff <= S_STEP_MUL;
            end
            S_STEP_MUL: begin
               // one axis per cycle: floor(acc*dt2 >> frac)
               term_ff[ax_ff] <= (66'(acc_ff[ax_ff]) * $signed({32'd0, dt2_ff}))
                                 >>> FRAC_BITS;
               if (ax_ff == 2'd2) begin
                  pi_ff <= '0; state_ff <= S_PT_RD;
               end else ax_ff <= ax_ff + 2'd1;
            end
            S_PT_RD: begin
               if (pi_ff == np_eff) begin
                  li_ff <= '0; pass_ff <= '0;
                  state_ff <= (npass_eff == 9'd0 || nl_eff == '0) ? S_RESP : S_LK_RD;
                  if (npass_eff == 9'd0 || nl_eff == '0) begin
                     kind_ff <= vcs_pkg::KIND_DONE; rsp_valid_ff <= 1'b1;
                  end
               end else state_ff <= S_PT_WAIT;
            end
            S_PT_WAIT: begin
               if (act_ff == vcs_pkg::ACT_READ_POINT) begin
                  ox_ff <= rc_ff[0]; oy_ff <= rc_ff[1]; oz_ff <= rc_ff[2];
                  opin_ff <= rpin_ff; rsp_valid_ff <= 1'b1; state_ff <= S_RESP;
               end else state_ff <= S_PT_WR;
            end
            S_PT_WR: begin
               pi_ff <= pi_ff + PCW'(1); state_ff <= S_PT_RD;
            end
            S_LK_RD: state_ff <= S_LK_WAIT;
            S_LK_WAIT: begin
               la_ff <= PW'(rlink_ff[19:10]); lb_ff <= PW'(rlink_ff[9:0]);
               if (rlink_ff[20] || 32'(rlink_ff[19:10]) >= 32'(MAX_POINTS)
                   || 32'(rlink_ff[9:0]) >= 32'(MAX_POINTS))
                  state_ff <= S_LK_NEXT;
               else state_ff <= S_LK_PRD;
            end
            S_LK_PRD: state_ff <= S_LK_PWAIT;
            S_LK_PWAIT: begin
               ca_ff <= rc_ff; pa_ff <= rpin_ff; state_ff <= S_LK_AXIS;
            end
            S_LK_AXIS: begin
               cb_ff <= rc_ff; pb_ff <= rpin_ff;
               for (int k = 0; k < 3; k++)
                  axis_ff[k] <= vcs_pkg::sat32(66'(ca_ff[k]) - 66'(rc_ff[k]));
               ax_ff <= 2'd0;
               state_ff <= (pa_ff && rpin_ff) ? S_LK_NEXT : S_LK_SQ;
            end
            S_LK_SQ: begin
               // square one axis per cycle
               sq_ff[ax_ff] <= 64'(axis_ff[ax_ff] * axis_ff[ax_ff]);
               if (ax_ff == 2'd2) state_ff <= S_LK_SUM;
               else ax_ff <= ax_ff + 2'd1;
            end
            S_LK_SUM: begin
               dnum_ff <= 96'(sq_ff[0]) + 96'(sq_ff[1]) + 96'(sq_ff[2]);
               dsq_ff <= 1'b1; dstart_ff <= 1'b1;
               state_ff <= S_LK_SQRT;
            end
            S_LK_SQRT: begin
               if (ddone) begin
                  delta_ff <= sq_delta;
                  ax_ff <= 2'd0;
                  if (32'(dquo[31:0]) < 32'(MinLen)) state_ff <= S_LK_NEXT;
                  else begin
                     // start first axis divide
                     state_ff <= S_LK_DIV;
                     dden_ff <= (pa_ff || pb_ff) ? 64'(dquo[31:0]) : 64'(dquo[31:0]) << 1;
                     dneg_ff <= axis_ff[0][31] ^ sq_delta[33];
                     dnum_ff <= 96'((axis_ff[0][31] ? -66'(axis_ff[0]) : 66'(axis_ff[0]))
                        * (sq_delta[33] ? -66'(sq_delta) : 66'(sq_delta)));
                     dsq_ff <= 1'b0; dstart_ff <= 1'b1;
                  end
               end
            end
            S_LK_DIV: begin
               if (ddone) begin
                  corr_ff[ax_ff] <= 34'(dneg_ff ? -66'(dquo[65:0]) : 66'(dquo[65:0]));
                  if (ax_ff == 2'd2) state_ff <= S_LK_WA;
                  else begin
                     ax_ff <= ax_ff + 2'd1;
                     dneg_ff <= axis_ff[ax_ff + 2'd1][31] ^ delta_ff[33];
                     dnum_ff <= 96'((axis_ff[ax_ff + 2'd1][31]
                                     ? -66'(axis_ff[ax_ff + 2'd1])
                                     : 66'(axis_ff[ax_ff + 2'd1]))
                                    * (delta_ff[33] ? -66'(delta_ff) : 66'(delta_ff)));
                     dsq_ff <= 1'b0; dstart_ff <= 1'b1;
                  end
               end
            end
            S_LK_WA: state_ff <= S_LK_WB;
            S_LK_WB: state_ff <= S_LK_NEXT;
            S_LK_NEXT: begin
               if (li_ff + LCW'(1) == nl_eff) begin
                  li_ff <= '0;
                  if (pass_ff + 9'd1 == npass_eff) begin
                     kind_ff <= vcs_pkg::KIND_DONE; rsp_valid_ff <= 1'b1;
                     state_ff <= S_RESP;
                  end else begin
                     pass_ff <= pass_ff + 9'd1; state_ff <= S_LK_RD;
                  end
               end else begin
                  li_ff <= li_ff + LCW'(1); state_ff <= S_LK_RD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   // A response only stands while the sequencer waits for it to drain.
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_RESP) else $error("response outside drain state");
   // A new transaction is never accepted while a response is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request accepted with response pending");
   // The iterative unit only finishes while a link waits on it.
   a_unit_done: assert property (@(posedge clock) disable iff (reset)
      ddone |-> (state_ff == S_LK_SQRT || state_ff == S_LK_DIV))
      else $error("unit result with no consumer");
`endif
endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the cloth step engine: stimulus, prediction and checks.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit = 1000000;
   localparam int MinLen    = ((1 << vcs_pkg::FracBits) + 9999) / 10000;

   typedef struct {
      vcs_pkg::action_type act;
      logic [11:0]        idx;
      logic signed [31:0] px, py, pz;
      logic               flag;
      logic [9:0]         ea, eb;
      logic signed [31:0] wx, wy, wz;
      logic [16:0]        dt;
   } cloth_req_type;

   typedef struct {
      logic [1:0]         kind;
      logic signed [31:0] x, y, z;
      logic               pin;
   } cloth_rsp_type;

   // Predicts responses from a private copy of the cloth state and registers.
   class cloth_scoreboard_type;
      logic signed [31:0] grav[3];
      logic [30:0]        rest;
      logic [6:0]         passes;
      logic [10:0]        npts;
      logic [12:0]        nlnk;
      logic signed [31:0] cur[3][vcs_pkg::MaxPoints];
      logic signed [31:0] prv[3][vcs_pkg::MaxPoints];
      logic               pin[vcs_pkg::MaxPoints];
      logic [9:0]         la[vcs_pkg::MaxLinks], lb[vcs_pkg::MaxLinks];
      logic               lskip[vcs_pkg::MaxLinks];
      cloth_rsp_type      pending[$];
      int                 errors;

      function new();
         grav = '{0, -642253, 0};
         rest = 65536;
         passes = 8;
         npts = 0;
         nlnk = 0;
         errors = 0;
      endfunction

      function void set_reg(logic [2:0] r, logic [31:0] d);
         case (r)
            vcs_pkg::REG_GRAV_X: grav[0] = d;
            vcs_pkg::REG_GRAV_Y: grav[1] = d;
            vcs_pkg::REG_GRAV_Z: grav[2] = d;
            vcs_pkg::REG_REST:   rest = d[30:0];
            vcs_pkg::REG_PASSES: passes = d[6:0];
            vcs_pkg::REG_POINTS: npts = d[10:0];
            vcs_pkg::REG_LINKS:  nlnk = d[12:0];
            default: ;
         endcase
      endfunction

      function longint clamp(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint unsigned root(longint unsigned v);
         longint unsigned res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v -= res + b;
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         return res;
      endfunction

      // Pull one link toward the rest length; pinned ends stay put.
      function void relax(int i);
         int a, b, k;
         bit pa, pb;
         longint d[3], c[3], len, delta, dv;
         longint unsigned sum;
         a = la[i];
         b = lb[i];
         pa = pin[a];
         pb = pin[b];
         if (pa && pb) return;
         sum = 0;
         for (k = 0; k < 3; k++) begin
            d[k] = clamp(longint'(cur[k][a]) - longint'(cur[k][b]));
            sum += longint'(d[k] * d[k]);
         end
         len = longint'(root(sum));
         if (len < MinLen) return;
         delta = longint'({33'd0, rest}) - len;
         dv = (pa || pb) ? len : 2 * len;
         for (k = 0; k < 3; k++) c[k] = (d[k] * delta) / dv;
         for (k = 0; k < 3; k++) begin
            if (!pa) cur[k][a] = clamp(longint'(cur[k][a]) + c[k]);
            if (!pb) cur[k][b] = clamp(longint'(cur[k][b]) - c[k]);
         end
      endfunction

      // Integrate free points, then relax links pass by pass.
      function void run_step(cloth_req_type q);
         longint dt2, nx;
         longint term[3];
         logic signed [31:0] w[3];
         int np, nl, npass, i, p, k;
         dt2 = (longint'({47'd0, q.dt}) * longint'({47'd0, q.dt})) >>> vcs_pkg::FracBits;
         w = '{q.wx, q.wy, q.wz};
         for (k = 0; k < 3; k++)
            term[k] = (clamp(longint'(grav[k]) + longint'(w[k])) * dt2)
                      >>> vcs_pkg::FracBits;
         np = (npts > vcs_pkg::MaxPoints) ? vcs_pkg::MaxPoints : npts;
         nl = (nlnk > vcs_pkg::MaxLinks) ? vcs_pkg::MaxLinks : nlnk;
         npass = (passes > vcs_pkg::MaxPasses) ? vcs_pkg::MaxPasses : passes;
         for (i = 0; i < np; i++) begin
            if (!pin[i]) begin
               for (k = 0; k < 3; k++) begin
                  nx = clamp(2 * longint'(cur[k][i]) - longint'(prv[k][i]) + term[k]);
                  prv[k][i] = cur[k][i];
                  cur[k][i] = nx;
               end
            end
         end
         for (p = 0; p < npass; p++)
            for (i = 0; i < nl; i++)
               if (!lskip[i]) relax(i);
      endfunction

      function void note_request(cloth_req_type q);
         cloth_rsp_type e;
         e = '{vcs_pkg::KIND_ACK, 0, 0, 0, 0};
         case (q.act)
            vcs_pkg::ACT_LOAD_POINT: if (q.idx < vcs_pkg::MaxPoints) begin
               cur[0][q.idx] = q.px; prv[0][q.idx] = q.px;
               cur[1][q.idx] = q.py; prv[1][q.idx] = q.py;
               cur[2][q.idx] = q.pz; prv[2][q.idx] = q.pz;
               pin[q.idx] = q.flag;
            end
            vcs_pkg::ACT_LOAD_LINK: if (q.idx < vcs_pkg::MaxLinks) begin
               lskip[q.idx] = q.flag;
               la[q.idx] = q.ea;
               lb[q.idx] = q.eb;
            end
            vcs_pkg::ACT_STEP: begin
               run_step(q);
               e.kind = vcs_pkg::KIND_DONE;
            end
            default: begin
               e.kind = vcs_pkg::KIND_POINT;
               if (q.idx < vcs_pkg::MaxPoints) begin
                  e.x = cur[0][q.idx];
                  e.y = cur[1][q.idx];
                  e.z = cur[2][q.idx];
                  e.pin = pin[q.idx];
               end
            end
         endcase
         pending.push_back(e);
      endfunction

      function void check_response(cloth_rsp_type g);
         cloth_rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected response kind %0d", g.kind);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (g.kind !== e.kind) begin
            $error("kind: expected %0d actual %0d", e.kind, g.kind); errors++;
         end
         if (g.x !== e.x) begin
            $error("out_x: expected %0d actual %0d", e.x, g.x); errors++;
         end
         if (g.y !== e.y) begin
            $error("out_y: expected %0d actual %0d", e.y, g.y); errors++;
         end
         if (g.z !== e.z) begin
            $error("out_z: expected %0d actual %0d", e.z, g.z); errors++;
         end
         if (g.pin !== e.pin) begin
            $error("out_pinned: expected %0d actual %0d", e.pin, g.pin); errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_action = 0;
   logic [11:0] req_index = 0;
   logic signed [31:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic req_flag = 0;
   logic [9:0] req_end_a = 0, req_end_b = 0;
   logic signed [31:0] req_wind_x = 0, req_wind_y = 0, req_wind_z = 0;
   logic [16:0] req_time_step = 0;
   logic rsp_valid;
   logic rsp_stall = 1;
   logic [1:0] rsp_kind;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic rsp_out_pinned;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = 0;
   logic [31:0] csr_data = 0;

   cloth_scoreboard_type sb = new();
   int send_pct = 0, recv_pct = 0;
   int hold_cnt = 0;
   bit hold_go = 0;
   int idle_cycles = 0;
   int pt_hi = 0, ln_hi = 0;
   int n_steps = 0, n_reads = 0, n_loads = 0;

   verlet_cloth_step u_top (.*);

   always #5 clock = ~clock;

   // Receive side: check accepted responses, then pick the next stall value.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response('{rsp_kind, rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_pinned});
      if (hold_go) begin
         hold_cnt = 400;
         hold_go = 0;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_pct);
      end
   end

   // Watchdog: end the run if no transaction moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else if (++idle_cycles >= IdleLimit) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   task automatic send_item(cloth_req_type q);
      if ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= q.act;
      req_index <= q.idx;
      req_pos_x <= q.px;
      req_pos_y <= q.py;
      req_pos_z <= q.pz;
      req_flag <= q.flag;
      req_end_a <= q.ea;
      req_end_b <= q.eb;
      req_wind_x <= q.wx;
      req_wind_y <= q.wy;
      req_wind_z <= q.wz;
      req_time_step <= q.dt;
      do @(posedge clock); while (req_stall);
      sb.note_request(q);
      case (q.act)
         vcs_pkg::ACT_STEP: n_steps++;
         vcs_pkg::ACT_READ_POINT: n_reads++;
         default: n_loads++;
      endcase
   endtask

   task automatic do_point(int idx, logic [31:0] x, logic [31:0] y, logic [31:0] z, bit p);
      cloth_req_type q;
      q = '{vcs_pkg::ACT_LOAD_POINT, idx, x, y, z, p, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom};
      send_item(q);
   endtask

   task automatic do_link(int idx, int a, int b, bit s);
      cloth_req_type q;
      q = '{vcs_pkg::ACT_LOAD_LINK, idx, $urandom, $urandom, $urandom, s, a, b, $urandom,
            $urandom, $urandom, $urandom};
      send_item(q);
   endtask

   task automatic do_step(logic [31:0] wx, logic [31:0] wy, logic [31:0] wz, int dt);
      cloth_req_type q;
      q = '{vcs_pkg::ACT_STEP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, wx, wy, wz, dt};
      send_item(q);
   endtask

   task automatic do_read(int idx);
      cloth_req_type q;
      q = '{vcs_pkg::ACT_READ_POINT, idx, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom, $urandom};
      send_item(q);
   endtask

   // Drop the request valid, write one register, then idle the port.
   task automatic csr_write(logic [2:0] r, logic [31:0] d);
      req_valid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= r;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_reg(r, d);
      @(posedge clock);
   endtask

   // Hold the request channel until every response is back, then let the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      if ($urandom_range(3) == 0) return $urandom;
      return $urandom_range(524288) - 262144;
   endfunction

   function automatic logic [31:0] rand_accel();
      if ($urandom_range(3) == 0) return $urandom;
      return $urandom_range(131072) - 65536;
   endfunction

   // Load points and links from zero upward; links only join loaded points.
   task automatic build_cloth(int np, int nl, bit mostly_skip);
      int i;
      for (i = 0; i < np; i++)
         do_point(i, rand_coord(), rand_coord(), rand_coord(), $urandom_range(3) == 0);
      if (np > pt_hi) pt_hi = np;
      for (i = 0; i < nl; i++)
         do_link(i, $urandom_range(pt_hi - 1), $urandom_range(pt_hi - 1),
                 mostly_skip ? (i > 1) : ($urandom_range(4) == 0));
      if (nl > ln_hi) ln_hi = nl;
   endtask

   task automatic random_items(int n);
      int i, r;
      for (i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 30)
            do_point(($urandom_range(9) == 0) ? $urandom_range(4095, vcs_pkg::MaxPoints)
                                              : $urandom_range(pt_hi - 1),
                     rand_coord(), rand_coord(), rand_coord(), $urandom_range(1));
         else if (r < 50)
            do_link($urandom_range(ln_hi - 1), $urandom_range(pt_hi - 1),
                    $urandom_range(pt_hi - 1), $urandom_range(4) == 0);
         else if (r < 85)
            do_read(($urandom_range(7) == 0) ? $urandom_range(4095, vcs_pkg::MaxPoints)
                                             : $urandom_range(pt_hi - 1));
         else
            do_step(rand_accel(), rand_accel(), rand_accel(), $urandom_range(65536));
      end
   endtask

   initial begin
      int i;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty cloth, out-of-range indexes, saturating and degenerate links.
      do_step(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 65536);
      do_read(4095);
      do_read(vcs_pkg::MaxPoints);
      do_point(2000, 32'h1234, 32'h5678, 32'h9abc, 1);
      do_point(0, 0, 0, 0, 1);
      do_point(1, 65536, 0, 0, 0);
      do_point(2, 0, 65536, 0, 1);
      do_point(3, 32'h80000000, 32'h80000000, 32'h80000000, 0);
      do_point(4, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
      do_point(5, 3, 0, 0, 0);
      do_link(0, 0, 1, 0);
      do_link(1, 1, 1, 0);
      do_link(2, 0, 2, 0);
      do_link(3, 1, 4, 1);
      do_link(4, 3, 4, 0);
      do_link(5, 5, 0, 0);
      pt_hi = 6;
      ln_hi = 6;
      drain();
      csr_write(vcs_pkg::REG_POINTS, 6);
      csr_write(vcs_pkg::REG_LINKS, 6);
      csr_write(vcs_pkg::REG_PASSES, 2);
      do_step(0, 0, 0, 65536);
      for (i = 0; i < 6; i++) do_read(i);
      do_step(32'h80000000, 32'h80000000, 32'h80000000, 0);
      do_read(4);
      drain();

      // Phase A: sender idles rarely, receiver stalls often, extreme gravity, longest rest length.
      send_pct = 30;
      recv_pct = 67;
      csr_write(vcs_pkg::REG_GRAV_X, 32'h80000000);
      csr_write(vcs_pkg::REG_GRAV_Y, $urandom);
      csr_write(vcs_pkg::REG_GRAV_Z, 32'h7fffffff);
      csr_write(vcs_pkg::REG_REST, 32'hffffffff);
      csr_write(vcs_pkg::REG_PASSES, 3);
      build_cloth(8, 6, 0);
      csr_write(vcs_pkg::REG_POINTS, 8);
      csr_write(vcs_pkg::REG_LINKS, 6);
      // Back-pressure: stall responses for a long stretch while requests keep coming.
      hold_go = 1;
      send_pct = 0;
      for (i = 0; i < 8; i++) do_read($urandom_range(pt_hi - 1));
      send_pct = 30;
      random_items(20);
      drain();

      // Phase B: sender idles often, receiver stalls rarely, zero rest length, maximum passes.
      send_pct = 67;
      recv_pct = 30;
      csr_write(vcs_pkg::REG_GRAV_X, rand_accel());
      csr_write(vcs_pkg::REG_GRAV_Y, rand_accel());
      csr_write(vcs_pkg::REG_GRAV_Z, rand_accel());
      csr_write(vcs_pkg::REG_REST, 0);
      csr_write(vcs_pkg::REG_PASSES, vcs_pkg::MaxPasses);
      csr_write(vcs_pkg::REG_POINTS, 6);
      csr_write(vcs_pkg::REG_LINKS, 3);
      random_items(20);
      drain();

      // Phase C: no idling; no passes, then passes above the maximum.
      send_pct = 0;
      recv_pct = 0;
      csr_write(vcs_pkg::REG_REST, $urandom_range(200000));
      csr_write(vcs_pkg::REG_PASSES, 0);
      csr_write(vcs_pkg::REG_POINTS, 8);
      csr_write(vcs_pkg::REG_LINKS, 6);
      random_items(10);
      drain();
      csr_write(vcs_pkg::REG_PASSES, 127);
      csr_write(vcs_pkg::REG_LINKS, 2);
      random_items(10);
      drain();

      $display("tb_top: %0d loads, %0d reads and %0d steps checked", n_loads, n_reads,
               n_steps);
      $display("tb_top: covered idle mixes, long response stall, pass count extremes");
      if (sb.errors == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end
endmodule
`default_nettype wire
